// ===== rtl/ppc_pkg.sv =====
// Shared types and codes for the product parity codec.
// No dependencies; imported by every module of the block.
`default_nettype none

package ppc_pkg;

  localparam int WORD_W   = 16;
  localparam int STATUS_W = 2;

  // command codes
  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] ST_CLEAN     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_CORRECTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_CHECK_ERR = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RESEND    = 2'd3;

  // side information carried alongside the data grid
  typedef struct packed {
    logic cmd;      // command of the item
    logic parity0;  // stored overall parity bit (decode only)
  } ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/ppc_check.sv =====
// Grid extraction and row/column syndrome stage of the product parity codec.
// Depends on ppc_pkg.
`default_nettype none

module ppc_check #(
  parameter int DATA_COLUMNS = 3,
  parameter int DATA_ROWS    = 3
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  wire                                   in_cmd,
  input  wire  [ppc_pkg::WORD_W-1:0]            in_payload,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output ppc_pkg::ctrl_t                        out_ctrl,
  output logic [DATA_ROWS*DATA_COLUMNS-1:0]     out_data,
  output logic [DATA_ROWS-1:0]                  out_row_syn,
  output logic [DATA_COLUMNS-1:0]               out_col_syn
);
  import ppc_pkg::*;

  localparam int GRID_W = DATA_COLUMNS + 1;
  localparam int DATA_N = DATA_ROWS * DATA_COLUMNS;

  logic [DATA_N-1:0]       data_bits;
  logic [DATA_ROWS-1:0]    row_stored;
  logic [DATA_COLUMNS-1:0] col_stored;
  logic [DATA_ROWS-1:0]    row_syn_next;
  logic [DATA_COLUMNS-1:0] col_syn_next;
  logic                    load;

  // pick each data bit from its encode or decode position; positions past
  // the word read as zero
  for (genvar r = 0; r < DATA_ROWS; r++) begin : g_row
    localparam int ROW_POS = GRID_W * (r + 1);
    if (ROW_POS < WORD_W) begin : g_rs
      assign row_stored[r] = in_payload[ROW_POS];
    end else begin : g_rz
      assign row_stored[r] = 1'b0;
    end
    for (genvar c = 0; c < DATA_COLUMNS; c++) begin : g_col
      localparam int K       = r * DATA_COLUMNS + c;
      localparam int DEC_POS = GRID_W * (r + 1) + c + 1;
      logic enc_bit;
      logic dec_bit;
      if (K < WORD_W) begin : g_ek
        assign enc_bit = in_payload[K];
      end else begin : g_ez
        assign enc_bit = 1'b0;
      end
      if (DEC_POS < WORD_W) begin : g_dk
        assign dec_bit = in_payload[DEC_POS];
      end else begin : g_dz
        assign dec_bit = 1'b0;
      end
      assign data_bits[K] = (in_cmd == CMD_DECODE) ? dec_bit : enc_bit;
    end
  end

  for (genvar c = 0; c < DATA_COLUMNS; c++) begin : g_cs
    assign col_stored[c] = in_payload[c + 1];
  end

  // encode: plain parities; decode: fold in the stored check bits
  always_comb begin
    for (int r = 0; r < DATA_ROWS; r++) begin
      row_syn_next[r] = row_stored[r] & (in_cmd == CMD_DECODE);
      for (int c = 0; c < DATA_COLUMNS; c++) begin
        row_syn_next[r] = row_syn_next[r] ^ data_bits[r * DATA_COLUMNS + c];
      end
    end
    for (int c = 0; c < DATA_COLUMNS; c++) begin
      col_syn_next[c] = col_stored[c] & (in_cmd == CMD_DECODE);
      for (int r = 0; r < DATA_ROWS; r++) begin
        col_syn_next[c] = col_syn_next[c] ^ data_bits[r * DATA_COLUMNS + c];
      end
    end
  end

  assign in_ready = !out_valid || out_ready;
  assign load     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_ctrl.cmd     <= in_cmd;
      out_ctrl.parity0 <= in_payload[0];
      out_data         <= data_bits;
      out_row_syn      <= row_syn_next;
      out_col_syn      <= col_syn_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ppc_resolve.sv =====
// Correction, codeword assembly and status stage of the product parity codec;
// holds the output register. Depends on ppc_pkg.
`default_nettype none

module ppc_resolve #(
  parameter int DATA_COLUMNS = 3,
  parameter int DATA_ROWS    = 3
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  ppc_pkg::ctrl_t                        in_ctrl,
  input  wire  [DATA_ROWS*DATA_COLUMNS-1:0]     in_data,
  input  wire  [DATA_ROWS-1:0]                  in_row_syn,
  input  wire  [DATA_COLUMNS-1:0]               in_col_syn,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic                                  out_cmd,
  output logic [ppc_pkg::WORD_W-1:0]            out_word,
  output logic [ppc_pkg::STATUS_W-1:0]          out_status
);
  import ppc_pkg::*;

  localparam int GRID_W = DATA_COLUMNS + 1;
  localparam int GRID_N = GRID_W * (DATA_ROWS + 1);
  localparam int DATA_N = DATA_ROWS * DATA_COLUMNS;

  logic [DATA_N-1:0]   fixed_data;
  logic [GRID_N-1:0]   enc_grid;
  logic [WORD_W-1:0]   enc_word;
  logic [WORD_W-1:0]   dec_word;
  logic                row_zero, row_one, col_zero, col_one, single;
  logic                parity_ok;
  logic [STATUS_W-1:0] status_next;
  logic                load;

  // zero and exactly-one tests on the syndromes
  assign row_zero = ~|in_row_syn;
  assign col_zero = ~|in_col_syn;
  assign row_one  = !row_zero && ~|(in_row_syn & (in_row_syn - DATA_ROWS'(1)));
  assign col_one  = !col_zero && ~|(in_col_syn & (in_col_syn - DATA_COLUMNS'(1)));
  assign single   = row_one && col_one && (in_ctrl.cmd == CMD_DECODE);

  // flip the bit at the crossing of the failing row and column
  for (genvar r = 0; r < DATA_ROWS; r++) begin : g_fr
    for (genvar c = 0; c < DATA_COLUMNS; c++) begin : g_fc
      localparam int K = r * DATA_COLUMNS + c;
      assign fixed_data[K] = in_data[K] ^ (single & in_row_syn[r] & in_col_syn[c]);
      assign enc_grid[GRID_W * (r + 1) + c + 1] = in_data[K];
    end
    assign enc_grid[GRID_W * (r + 1)] = in_row_syn[r];
  end
  for (genvar c = 0; c < DATA_COLUMNS; c++) begin : g_ec
    assign enc_grid[c + 1] = in_col_syn[c];
  end
  assign enc_grid[0] = ^in_data;

  if (GRID_N >= WORD_W) begin : g_ew
    assign enc_word = enc_grid[WORD_W-1:0];
  end else begin : g_ewz
    assign enc_word = {{(WORD_W - GRID_N){1'b0}}, enc_grid};
  end
  if (DATA_N >= WORD_W) begin : g_dw
    assign dec_word = fixed_data[WORD_W-1:0];
  end else begin : g_dwz
    assign dec_word = {{(WORD_W - DATA_N){1'b0}}, fixed_data};
  end

  assign parity_ok = (^fixed_data) == in_ctrl.parity0;

  always_comb begin
    if (in_ctrl.cmd == CMD_ENCODE) begin
      status_next = ST_CLEAN;
    end else if (row_zero && col_zero) begin
      status_next = parity_ok ? ST_CLEAN : ST_CHECK_ERR;
    end else if (row_one && col_one) begin
      status_next = parity_ok ? ST_CORRECTED : ST_RESEND;
    end else if ((row_one && col_zero) || (row_zero && col_one)) begin
      status_next = parity_ok ? ST_CHECK_ERR : ST_RESEND;
    end else begin
      status_next = ST_RESEND;
    end
  end

  assign in_ready = !out_valid || out_ready;
  assign load     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_cmd    <= in_ctrl.cmd;
      out_word   <= (in_ctrl.cmd == CMD_ENCODE) ? enc_word : dec_word;
      out_status <= status_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/product_parity_codec_3x3.sv =====
// Top level of the product parity codec: input register, syndrome stage and
// output stage. Depends on ppc_pkg, ppc_check and ppc_resolve.
//
//  channel  | direction | tdata             | tuser
//  ---------+-----------+-------------------+-----------------
//  s_axis   | in        | [15:0] payload    | [0] command
//  m_axis   | out       | [15:0] result_word| [1:0] status
//
// One transfer a cycle in each direction, sustained while m_tready stays high; every item is independent.
// m_tvalid follows the input transfer through the input register, the
// grid/syndrome register and the output register, in that order.
// Reset (rst, synchronous) clears the three stage valid bits only.
// A stall at m_tready holds the output stage; each stage upstream keeps
// loading until it is full, so nothing is dropped or repeated.
`default_nettype none

module product_parity_codec_3x3 #(
  parameter int DATA_COLUMNS = 3,
  parameter int DATA_ROWS    = 3
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               s_tvalid,
  output logic                              s_tready,
  input  wire  [ppc_pkg::WORD_W-1:0]        s_tdata,   // [15:0] payload
  input  wire                               s_tuser,   // [0] command
  output logic                              m_tvalid,
  input  wire                               m_tready,
  output logic [ppc_pkg::WORD_W-1:0]        m_tdata,   // [15:0] result_word
  output logic [ppc_pkg::STATUS_W-1:0]      m_tuser    // [1:0] status
);
  import ppc_pkg::*;

  localparam int DATA_N = DATA_ROWS * DATA_COLUMNS;

  // input register
  logic              a_valid;
  logic              a_cmd;
  logic [WORD_W-1:0] a_payload;
  logic              b_ready;

  // syndrome stage outputs
  logic                    b_valid;
  ctrl_t                   b_ctrl;
  logic [DATA_N-1:0]       b_data;
  logic [DATA_ROWS-1:0]    b_row_syn;
  logic [DATA_COLUMNS-1:0] b_col_syn;
  logic                    c_ready;
  logic                    c_cmd;

  assign s_tready = !a_valid || b_ready;

  // advance the input register whenever it is empty or the next stage can take its contents
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_tready) begin
      a_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      a_cmd     <= s_tuser;
      a_payload <= s_tdata;
    end
  end

  ppc_check #(
    .DATA_COLUMNS (DATA_COLUMNS),
    .DATA_ROWS    (DATA_ROWS)
  ) u_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (a_valid),
    .in_ready    (b_ready),
    .in_cmd      (a_cmd),
    .in_payload  (a_payload),
    .out_valid   (b_valid),
    .out_ready   (c_ready),
    .out_ctrl    (b_ctrl),
    .out_data    (b_data),
    .out_row_syn (b_row_syn),
    .out_col_syn (b_col_syn)
  );

  ppc_resolve #(
    .DATA_COLUMNS (DATA_COLUMNS),
    .DATA_ROWS    (DATA_ROWS)
  ) u_resolve (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (b_valid),
    .in_ready   (c_ready),
    .in_ctrl    (b_ctrl),
    .in_data    (b_data),
    .in_row_syn (b_row_syn),
    .in_col_syn (b_col_syn),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_cmd    (c_cmd),
    .out_word   (m_tdata),
    .out_status (m_tuser)
  );

`ifndef SYNTHESIS
  // an empty input register must always take a transfer
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !a_valid |-> s_tready)
    else $error("input register empty but s_tready low");

  // a held input item must not change while the syndrome stage is stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    a_valid && !b_ready |=> a_valid && $stable(a_cmd) && $stable(a_payload))
    else $error("input register lost or changed a stalled item");

  // encoded words always report a clean status
  a_enc_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (c_cmd == CMD_ENCODE) |-> m_tuser == ST_CLEAN)
    else $error("encode result with non-clean status");

  // a held syndrome-stage item must not change while the output stage is stalled
  b_hold: assert property (@(posedge clk) disable iff (rst)
    b_valid && !c_ready |=> b_valid && $stable(b_data) && $stable(b_ctrl))
    else $error("syndrome stage lost or changed a stalled item");
`endif

endmodule

`default_nettype wire
